// ----- hdl/assert_macros.svh -----
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check a property including during reset.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ----- hdl/itc_pkg.sv -----
package itc_pkg;

  localparam int unsigned TileSize = 256;
  localparam int unsigned TileBits = 8;
  localparam int unsigned MaxTiles = 1024;
  localparam int unsigned TileIdxW = 10;
  localparam int unsigned MaxSlots = 64;
  localparam int unsigned SlotW = 6;
  localparam int unsigned CntW = 7;
  localparam int unsigned DimW = 14;
  localparam int unsigned CoordW = 13;

  localparam logic [1:0] CfgWidth = 2'd0;
  localparam logic [1:0] CfgHeight = 2'd1;
  localparam logic [1:0] CfgLimit = 2'd2;

  localparam logic [1:0] FillNone = 2'd0;
  localparam logic [1:0] FillClear = 2'd1;
  localparam logic [1:0] FillLoad = 2'd2;

  typedef struct packed {
    logic action;
    logic [CoordW-1:0] pixel_x;
    logic [CoordW-1:0] pixel_y;
  } req_t;

  typedef struct packed {
    logic error;
    logic hit;
    logic [SlotW-1:0] slot;
    logic [15:0] pixel_offset;
    logic evict_valid;
    logic [TileIdxW-1:0] evicted_tile;
    logic write_back;
    logic [1:0] fill_mode;
  } rsp_t;

endpackage

// ----- hdl/itc_cell.sv -----
// One recency cell: holds the tile owning a slot; cell 0 is the most recent.
module itc_cell (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              shift_i,
  input  logic                              valid_i,
  input  logic [itc_pkg::TileIdxW-1:0]      tile_i,
  input  logic [itc_pkg::SlotW-1:0]         slot_i,
  input  logic                              dirty_i,
  input  logic [itc_pkg::TileIdxW-1:0]      probe_i,
  output logic                              valid_o,
  output logic [itc_pkg::TileIdxW-1:0]      tile_o,
  output logic [itc_pkg::SlotW-1:0]         slot_o,
  output logic                              dirty_o,
  output logic                              match_o
);
  logic valid_q, valid_d;
  logic [itc_pkg::TileIdxW-1:0] tile_q, tile_d;
  logic [itc_pkg::SlotW-1:0] slot_q, slot_d;
  logic dirty_q, dirty_d;

  // Take the neighbor's entry when the chain shifts.
  always_comb begin
    valid_d = shift_i ? valid_i : valid_q;
    tile_d = shift_i ? tile_i : tile_q;
    slot_d = shift_i ? slot_i : slot_q;
    dirty_d = shift_i ? dirty_i : dirty_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tile_q <= tile_d;
    slot_q <= slot_d;
    dirty_q <= dirty_d;
  end

  assign valid_o = valid_q;
  assign tile_o = tile_q;
  assign slot_o = slot_q;
  assign dirty_o = dirty_q;
  assign match_o = valid_q && (tile_q == probe_i);
endmodule

// ----- hdl/image_tile_cache_lru.sv -----
// Channel  Dir  Handshake            Payload
// cfg      in   cfg_valid/cfg_ready  cfg_index_i, cfg_data_i
// in       in   in_valid/in_ready    itc_pkg::req_t
// out      out  out_valid/out_ready  itc_pkg::rsp_t
// An access runs in order: on acceptance the tile is decoded and its stored
// flag sampled into registers; the lookup then matches it against the row of
// recency cells, shifts the cells unless out of bounds, and loads the result.
// Reset clears the cells, the stored flags and all counters.
// A new access is taken while a result waits; its lookup holds until the
// output register is free again.
`include "assert_macros.svh"
module image_tile_cache_lru (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [1:0]                     cfg_index_i,
  input  logic [itc_pkg::DimW-1:0]       cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  itc_pkg::req_t                  in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output itc_pkg::rsp_t                  out_data_o
);
  localparam int unsigned N = itc_pkg::MaxSlots;

  logic [itc_pkg::DimW-1:0] width_q, height_q;
  logic [itc_pkg::CntW-1:0] limit_q;
  logic [itc_pkg::MaxTiles-1:0] stored_q;
  logic [itc_pkg::CntW-1:0] used_q;
  logic busy_q, out_valid_q;
  itc_pkg::req_t req_q;
  itc_pkg::rsp_t out_q;
  logic [itc_pkg::TileIdxW-1:0] tile_q;
  logic oob_q;
  logic stored_rd_q;

  logic [N-1:0] cv, cm, cd, shift;
  logic [itc_pkg::TileIdxW-1:0] ct [N];
  logic [itc_pkg::SlotW-1:0] cs [N];
  logic [itc_pkg::TileIdxW-1:0] nt [N];
  logic [itc_pkg::SlotW-1:0] ns [N];
  logic [N-1:0] nv, nd;

  // Configuration.
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= 14'd8192;
      height_q <= 14'd8192;
      limit_q <= 7'd64;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        itc_pkg::CfgWidth: width_q <= cfg_data_i;
        itc_pkg::CfgHeight: height_q <= cfg_data_i;
        itc_pkg::CfgLimit: limit_q <= cfg_data_i[itc_pkg::CntW-1:0];
        default: ;
      endcase
    end
  end

  // Decode tile number of the arriving beat.
  logic [6:0] across;
  logic [14:0] tile_full;
  logic [itc_pkg::TileIdxW-1:0] in_tile;
  logic in_oob;
  logic [itc_pkg::CntW-1:0] lim;
  always_comb begin
    across = 7'((15'(width_q) + 15'(itc_pkg::TileSize - 1)) >> itc_pkg::TileBits);
    tile_full = 15'(in_data_i.pixel_y[12:8]) * 15'(across) +
                15'(in_data_i.pixel_x[12:8]);
    in_tile = tile_full[itc_pkg::TileIdxW-1:0];
    in_oob = (14'(in_data_i.pixel_x) >= width_q) ||
             (14'(in_data_i.pixel_y) >= height_q) ||
             (tile_full >= 15'(itc_pkg::MaxTiles));
    lim = (limit_q == '0) ? 7'd1 : ((limit_q > 7'(N)) ? 7'(N) : limit_q);
  end

  // Match position in the chain.
  logic hit;
  logic [itc_pkg::SlotW-1:0] hpos;
  logic [N-1:0] upto;
  logic alloc;
  logic [itc_pkg::SlotW-1:0] oldest;
  always_comb begin
    hit = |cm;
    hpos = '0;
    for (int i = 0; i < N; i++) if (cm[i]) hpos = itc_pkg::SlotW'(i);
    alloc = !hit && (used_q < lim);
    // Oldest valid entry is at used_q-1 (cells fill from the front).
    oldest = itc_pkg::SlotW'(used_q - 7'd1);
    for (int i = 0; i < N; i++) begin
      if (hit) upto[i] = (i <= int'(hpos));
      else if (alloc) upto[i] = 1'b1;
      else upto[i] = (i <= int'(oldest));
    end
  end

  logic go;
  logic take;
  assign go = busy_q && !out_valid_q;
  assign take = in_valid_i && !busy_q;
  assign shift = (go && !oob_q) ? upto : '0;

  logic [itc_pkg::SlotW-1:0] sel_slot;
  logic [itc_pkg::TileIdxW-1:0] evt;
  logic ev;
  logic wb;
  always_comb begin
    sel_slot = hit ? cs[hpos] : (alloc ? itc_pkg::SlotW'(used_q) : cs[oldest]);
    evt = ct[oldest];
    ev = !hit && !alloc;
    wb = ev && cd[oldest];
  end

  // Wire the chain: cell 0 takes the accessed tile, others take the left one.
  for (genvar g = 0; g < N; g++) begin : g_cell
    if (g == 0) begin : g_head
      assign nv[g] = 1'b1;
      assign nt[g] = tile_q;
      assign ns[g] = sel_slot;
      assign nd[g] = (hit && cd[hpos]) || req_q.action;
    end else begin : g_body
      assign nv[g] = cv[g-1];
      assign nt[g] = ct[g-1];
      assign ns[g] = cs[g-1];
      assign nd[g] = cd[g-1];
    end
    itc_cell u_cell (
      .clk_i, .rst_ni, .shift_i(shift[g]), .valid_i(nv[g]), .tile_i(nt[g]),
      .slot_i(ns[g]), .dirty_i(nd[g]), .probe_i(tile_q), .valid_o(cv[g]),
      .tile_o(ct[g]), .slot_o(cs[g]), .dirty_o(cd[g]), .match_o(cm[g])
    );
  end

  // Form the result of the held access.
  itc_pkg::rsp_t rsp_d;
  always_comb begin
    rsp_d = '0;
    if (oob_q) begin
      rsp_d.error = 1'b1;
    end else begin
      rsp_d.hit = hit;
      rsp_d.slot = sel_slot;
      rsp_d.pixel_offset = {req_q.pixel_y[7:0], req_q.pixel_x[7:0]};
      rsp_d.evict_valid = ev;
      rsp_d.evicted_tile = ev ? evt : '0;
      rsp_d.write_back = wb;
      rsp_d.fill_mode = hit ? itc_pkg::FillNone :
        (stored_rd_q ? itc_pkg::FillLoad : itc_pkg::FillClear);
    end
  end

  // Sequence, flags and output.
  assign in_ready_o = !busy_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      out_valid_q <= 1'b0;
      used_q <= '0;
      stored_q <= '0;
    end else begin
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      if (take) busy_q <= 1'b1;
      if (go) begin
        busy_q <= 1'b0;
        out_valid_q <= 1'b1;
        if (!oob_q) begin
          if (alloc) used_q <= used_q + 7'd1;
          if (wb) stored_q[evt] <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      req_q <= in_data_i;
      tile_q <= in_tile;
      oob_q <= in_oob;
      stored_rd_q <= stored_q[in_tile];
    end
    if (go) out_q <= rsp_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o = out_q;

  `ASSERT_CLK(a_one_match, $onehot0(cm), "tile matched in two cells")
  `ASSERT_CLK(a_used_max, used_q <= 7'(N), "slot count above capacity")
  `ASSERT_CLK(a_no_take_busy, busy_q |-> !in_ready_o, "input taken while busy")
endmodule
